// ----- hdl/wteh_pkg.sv -----
// Shared types, constants and helpers for the 802.11 to Ethernet header rewrite.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps
`default_nettype none

package wteh_pkg;

    // Payload of one accepted input request.
    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } in_item_t;

    // Payload of one result request.
    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_last;
        logic       status;
    } out_item_t;

    // Header geometry.
    localparam int HDR_BASE_LEN  = 24;
    localparam int HDR_WDS_LEN   = 30;
    localparam int QOS_LEN       = 2;
    localparam int LLC_LEN       = 6;
    localparam int MAC_LEN       = 6;
    localparam int PREFIX_LEN    = 2 * MAC_LEN;
    localparam int PREFIX_IDX_W  = $clog2(PREFIX_LEN + 1);
    localparam int POS_W         = 6;

    // Byte offsets of the four address fields.
    localparam int ADDR1_OFS = 4;
    localparam int ADDR2_OFS = 10;
    localparam int ADDR3_OFS = 16;
    localparam int ADDR4_OFS = 24;

    // Only header bytes from addr1 through the end of addr4 are ever read.
    localparam int HDR_LO = ADDR1_OFS;
    localparam int HDR_HI = ADDR4_OFS + MAC_LEN - 1;

    // Frame control subtype nibble that marks a QoS data frame.
    localparam logic [3:0] SUBTYPE_QOS = 4'h8;

    // ToDS / FromDS codes.
    localparam logic [1:0] DS_NONE = 2'd0;
    localparam logic [1:0] DS_TO   = 2'd1;
    localparam logic [1:0] DS_FROM = 2'd2;
    localparam logic [1:0] DS_WDS  = 2'd3;

    // Twelve address bytes, destination first.
    typedef logic [PREFIX_LEN-1:0][7:0] prefix_t;

    // Work handed from the front to the back.
    typedef enum logic [1:0] {
        CMD_DATA   = 2'd0,
        CMD_ERR    = 2'd1,
        CMD_PREFIX = 2'd2
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t  kind;
        logic [7:0] data;
        logic       last;
        logic       with_byte;
    } cmd_t;

    typedef struct packed {
        logic enq;
        cmd_t cmd;
    } q_push_t;

    // Command queue depth.
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    // Bytes of header, QoS field and LLC/SNAP to drop before the payload.
    function automatic logic [POS_W-1:0] header_len(input logic [1:0] ds, input logic qos);
        logic [POS_W-1:0] h;
        h = (ds == DS_WDS) ? POS_W'(HDR_WDS_LEN) : POS_W'(HDR_BASE_LEN);
        if (qos)
        begin
            h = h + POS_W'(QOS_LEN);
        end
        return h + POS_W'(LLC_LEN);
    endfunction

endpackage

`default_nettype wire

// ----- hdl/wteh_front.sv -----
// Front end: accepts input bytes, buffers the MAC header and classifies each byte
// into a command for the back end. Depends on wteh_pkg.
`timescale 1ns / 1ps
`default_nettype none

module wteh_front (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  pass_through,
    input  wire                  push,
    input  wteh_pkg::in_item_t   push_item,
    output logic                 full,
    input  wire                  q_full,
    output wteh_pkg::q_push_t    q_push,
    output wteh_pkg::prefix_t    prefix,
    output logic                 busy,
    input  wire                  pf_done
);
    import wteh_pkg::*;

    logic [POS_W-1:0] pos_reg, pos_next;
    logic             in_payload_reg, in_payload_next;
    logic [1:0]       ds_reg;
    logic             qos_reg;
    logic             busy_reg, busy_next;
    logic [7:0]       hdr_reg [HDR_LO:HDR_HI];
    prefix_t          pf_reg;

    logic [POS_W-1:0] hlen;
    logic             at_prefix;
    logic             hdr_end;
    logic             accept;
    logic             hdr_wr;
    logic             set_busy;
    cmd_t             cmd;
    logic             enq;

    // Header length and the two positions that trigger the address prefix.
    // The length is only known once both frame control bytes of this frame are in.
    assign hlen      = header_len(ds_reg, qos_reg);
    assign at_prefix = !in_payload_reg && (pos_reg >= POS_W'(2)) && (pos_reg >= hlen);
    assign hdr_end   = !in_payload_reg && (pos_reg >= POS_W'(2))
                       && ((pos_reg + POS_W'(1)) == hlen);

    // Hold off a new prefix while the back end still reads the previous one.
    assign full   = q_full || (busy_reg && (at_prefix || hdr_end));
    assign accept = push && !full;

    // Classify the byte and update the frame position.
    always_comb
    begin
        cmd.kind        = CMD_DATA;
        cmd.data        = push_item.in_byte;
        cmd.last        = push_item.in_last;
        cmd.with_byte   = 1'b0;
        enq             = 1'b0;
        hdr_wr          = 1'b0;
        pos_next        = pos_reg;
        in_payload_next = in_payload_reg;
        if (accept)
        begin
            if (pass_through || in_payload_reg)
            begin
                enq = 1'b1;
                if (push_item.in_last)
                begin
                    pos_next        = '0;
                    in_payload_next = 1'b0;
                end
            end
            else if (at_prefix)
            begin
                enq           = 1'b1;
                cmd.kind      = CMD_PREFIX;
                cmd.with_byte = 1'b1;
                if (push_item.in_last)
                begin
                    pos_next = '0;
                end
                else
                begin
                    in_payload_next = 1'b1;
                end
            end
            else
            begin
                hdr_wr = 1'b1;
                if (push_item.in_last)
                begin
                    enq      = 1'b1;
                    cmd.kind = hdr_end ? CMD_PREFIX : CMD_ERR;
                    pos_next = '0;
                end
                else
                begin
                    pos_next = pos_reg + POS_W'(1);
                end
            end
        end
    end

    assign set_busy = enq && (cmd.kind == CMD_PREFIX);

    // The prefix buffer stays owned by the back end until it has read it out.
    always_comb
    begin
        busy_next = busy_reg;
        if (set_busy)
        begin
            busy_next = 1'b1;
        end
        else if (pf_done)
        begin
            busy_next = 1'b0;
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg        <= '0;
            in_payload_reg <= 1'b0;
            busy_reg       <= 1'b0;
        end
        else
        begin
            pos_reg        <= pos_next;
            in_payload_reg <= in_payload_next;
            busy_reg       <= busy_next;
        end
    end

    // Header bytes and the two frame control fields that steer the rewrite.
    always_ff @(posedge clk)
    begin
        if (hdr_wr)
        begin
            if (pos_reg == POS_W'(0))
            begin
                qos_reg <= (push_item.in_byte[7:4] == SUBTYPE_QOS);
            end
            if (pos_reg == POS_W'(1))
            begin
                ds_reg <= push_item.in_byte[1:0];
            end
            if ((pos_reg >= POS_W'(HDR_LO)) && (pos_reg <= POS_W'(HDR_HI)))
            begin
                hdr_reg[pos_reg[4:0]] <= push_item.in_byte;
            end
        end
    end

    // Pick destination and source addresses by ToDS / FromDS.
    always_ff @(posedge clk)
    begin
        if (set_busy)
        begin
            for (int i = 0; i < MAC_LEN; i++)
            begin
                case (ds_reg)
                    DS_NONE:
                    begin
                        pf_reg[i]           <= hdr_reg[ADDR1_OFS + i];
                        pf_reg[MAC_LEN + i] <= hdr_reg[ADDR2_OFS + i];
                    end
                    DS_TO:
                    begin
                        pf_reg[i]           <= hdr_reg[ADDR3_OFS + i];
                        pf_reg[MAC_LEN + i] <= hdr_reg[ADDR2_OFS + i];
                    end
                    DS_FROM:
                    begin
                        pf_reg[i]           <= hdr_reg[ADDR1_OFS + i];
                        pf_reg[MAC_LEN + i] <= hdr_reg[ADDR3_OFS + i];
                    end
                    default:
                    begin
                        pf_reg[i]           <= hdr_reg[ADDR3_OFS + i];
                        pf_reg[MAC_LEN + i] <= hdr_reg[ADDR4_OFS + i];
                    end
                endcase
            end
        end
    end

    assign q_push.enq = enq;
    assign q_push.cmd = cmd;
    assign prefix     = pf_reg;
    assign busy       = busy_reg;

endmodule

`default_nettype wire

// ----- hdl/wteh_fifo.sv -----
// Short command queue between the front and back ends, held in flip-flops.
// Depends on wteh_pkg.
`timescale 1ns / 1ps
`default_nettype none

module wteh_fifo (
    input  wire                clk,
    input  wire                rst_n,
    input  wteh_pkg::q_push_t  q_push,
    input  wire                deq,
    output wteh_pkg::cmd_t     head,
    output logic               q_empty,
    output logic               q_full
);
    import wteh_pkg::*;

    cmd_t               mem_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [Q_CNT_W-1:0] cnt_reg, cnt_next;
    logic               do_wr;
    logic               do_rd;

    assign q_empty = (cnt_reg == Q_CNT_W'(0));
    assign q_full  = (cnt_reg == Q_CNT_W'(Q_DEPTH));
    assign do_wr   = q_push.enq && !q_full;
    assign do_rd   = deq && !q_empty;
    assign head    = mem_reg[rd_ptr_reg];

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0
                                                                : wr_ptr_reg + Q_PTR_W'(1);
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0
                                                                : rd_ptr_reg + Q_PTR_W'(1);
        end
        if (do_wr && !do_rd)
        begin
            cnt_next = cnt_reg + Q_CNT_W'(1);
        end
        else if (do_rd && !do_wr)
        begin
            cnt_next = cnt_reg - Q_CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Queue storage.
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= q_push.cmd;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/wteh_back.sv -----
// Back end: carries out queued commands, expanding a prefix command into twelve
// address bytes, and holds the result in an output register. Depends on wteh_pkg.
`timescale 1ns / 1ps
`default_nettype none

module wteh_back (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wteh_pkg::cmd_t      head,
    input  wire                 q_empty,
    output logic                deq,
    input  wteh_pkg::prefix_t   prefix,
    output logic                pf_done,
    input  wire                 pop,
    output logic                empty,
    output wteh_pkg::out_item_t pop_item
);
    import wteh_pkg::*;

    logic                    out_valid_reg, out_valid_next;
    out_item_t               out_reg;
    out_item_t               res;
    logic [PREFIX_IDX_W-1:0] cnt_reg, cnt_next;
    logic                    load;
    logic                    produce;

    // A new result may enter when the output register is free or being taken.
    assign load    = !out_valid_reg || pop;
    assign produce = !q_empty && load;

    // Expand the command at the head of the queue.
    always_comb
    begin
        res      = '0;
        deq      = 1'b0;
        pf_done  = 1'b0;
        cnt_next = cnt_reg;
        if (produce)
        begin
            case (head.kind)
                CMD_DATA:
                begin
                    res.out_byte = head.data;
                    res.out_last = head.last;
                    deq          = 1'b1;
                end
                CMD_ERR:
                begin
                    res.out_last = 1'b1;
                    res.status   = 1'b1;
                    deq          = 1'b1;
                end
                CMD_PREFIX:
                begin
                    if (cnt_reg == PREFIX_IDX_W'(PREFIX_LEN))
                    begin
                        // The first payload byte follows the addresses.
                        res.out_byte = head.data;
                        res.out_last = head.last;
                        deq          = 1'b1;
                        cnt_next     = '0;
                    end
                    else
                    begin
                        res.out_byte = prefix[cnt_reg];
                        if (cnt_reg == PREFIX_IDX_W'(PREFIX_LEN - 1))
                        begin
                            pf_done = 1'b1;
                            if (head.with_byte)
                            begin
                                cnt_next = cnt_reg + PREFIX_IDX_W'(1);
                            end
                            else
                            begin
                                // Empty payload: the frame ends on the source address.
                                res.out_last = 1'b1;
                                deq          = 1'b1;
                                cnt_next     = '0;
                            end
                        end
                        else
                        begin
                            cnt_next = cnt_reg + PREFIX_IDX_W'(1);
                        end
                    end
                end
                default:
                begin
                    deq = 1'b1;
                end
            endcase
        end
    end

    // Output register valid flag.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (produce)
        begin
            out_valid_next = 1'b1;
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            cnt_reg       <= cnt_next;
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        if (produce)
        begin
            out_reg <= res;
        end
    end

    assign empty    = !out_valid_reg;
    assign pop_item = out_reg;

endmodule

`default_nettype wire

// ----- hdl/wifi_to_ethernet_header_rewrite.sv -----
// 802.11 to Ethernet header rewrite, top level: front end, command queue and back end.
// Depends on wteh_pkg, wteh_front, wteh_fifo and wteh_back.
//
// Usage:
//   Input bytes of an 802.11 frame are pushed with push / full, frame control first,
//   in_last on the final byte. Results are read with empty / pop; each carries one
//   output byte, its last flag and a status bit (1 marks a frame too short to hold
//   its header and LLC/SNAP, given as a single zero byte with last set).
//   cfg_we / cfg_wdata write the pass-through mode bit; write it only while idle.
//   Header bytes give no results; the first payload byte gives the 12 address bytes
//   followed by itself, and later payload bytes give one result each.
//   An accepted byte passes through the command queue into the output register.
//   Throughput: one byte per cycle while full is low; a prefix holds the queue head for
//   its twelve address bytes and the byte after them, so with the reader always ready
//   the input stalls after the first payload byte; the backlog drains in the next frame's silent header.
//   A 4-entry command queue and the output register decouple the two sides; while
//   the reader stalls the queue fills and full rises. A new prefix also waits until
//   the back end has read the previous one out of the prefix buffer.
//   Reset clears the frame position, the queue and the output register, and selects
//   conversion mode; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module wifi_to_ethernet_header_rewrite (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  cfg_we,
    input  wire                  cfg_wdata,
    input  wire                  push,
    input  wteh_pkg::in_item_t   push_item,
    output logic                 full,
    input  wire                  pop,
    output logic                 empty,
    output wteh_pkg::out_item_t  pop_item
);
    import wteh_pkg::*;

    logic    pass_through_reg;
    q_push_t q_push;
    cmd_t    head;
    logic    q_empty;
    logic    q_full;
    logic    deq;
    prefix_t prefix;
    logic    front_busy;
    logic    pf_done;

    // Mode register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pass_through_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            pass_through_reg <= cfg_wdata;
        end
    end

    wteh_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .pass_through (pass_through_reg),
        .push         (push),
        .push_item    (push_item),
        .full         (full),
        .q_full       (q_full),
        .q_push       (q_push),
        .prefix       (prefix),
        .busy         (front_busy),
        .pf_done      (pf_done)
    );

    wteh_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_push  (q_push),
        .deq     (deq),
        .head    (head),
        .q_empty (q_empty),
        .q_full  (q_full)
    );

    wteh_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (head),
        .q_empty  (q_empty),
        .deq      (deq),
        .prefix   (prefix),
        .pf_done  (pf_done),
        .pop      (pop),
        .empty    (empty),
        .pop_item (pop_item)
    );

`ifndef SYNTHESIS
    // The front end never issues a command into a full queue.
    assert property (@(posedge clk) disable iff (!rst_n) q_push.enq |-> !q_full)
        else $error("command issued into a full queue");

    // The back end only finishes a prefix that the front end has handed over.
    assert property (@(posedge clk) disable iff (!rst_n) pf_done |-> front_busy)
        else $error("prefix read out while the buffer is not owned");

    // An error result is a lone zero byte that ends the frame.
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && pop_item.status) |-> (pop_item.out_last && (pop_item.out_byte == 8'd0)))
        else $error("malformed error result");

    // A new prefix is never accepted while the old one is still being read.
    assert property (@(posedge clk) disable iff (!rst_n)
        (front_busy && !pf_done) |=> !($rose(front_busy)))
        else $error("prefix buffer overwritten");
`endif

endmodule

`default_nettype wire

// ----- tb/sv/testbench.sv -----
// Self-checking testbench for the 802.11 to Ethernet header rewrite block.
// Depends on wteh_pkg and wifi_to_ethernet_header_rewrite; a built-in predictor checks every
// result.
`timescale 1ns / 1ps

module testbench;
    import wteh_pkg::*;

    localparam int HDR_DEPTH     = 38;
    localparam int SETTLE_CYCLES = 8;
    localparam int LONG_STALL    = 300;
    localparam int STALL_LIMIT   = 3000;
    localparam int MAX_PRINTS    = 20;

    // Block ports; the inputs are known from time zero.
    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      cfg_we = 1'b0;
    logic      cfg_wdata = 1'b0;
    logic      push = 1'b0;
    in_item_t  push_item = '0;
    logic      full;
    logic      pop = 1'b0;
    logic      empty;
    out_item_t pop_item;

    // Stimulus and scoreboard state.
    in_item_t  pending_bytes[$];
    out_item_t expected_results[$];
    logic [7:0] frame_buf[$];
    int items_queued = 0;
    int items_accepted = 0;
    int results_checked = 0;
    int short_frames = 0;
    int fail_count = 0;
    int stall_cycles = 0;
    int rx_hold_left = 0;
    bit req_taken = 1'b0;
    bit no_idle = 1'b0;
    bit tx_hold = 1'b0;
    bit long_stall_armed = 1'b0;
    bit long_stall_done = 1'b0;

    // Predictor state.
    logic [7:0] hdr_store[HDR_DEPTH];
    logic [5:0] byte_pos = '0;
    bit         in_payload = 1'b0;
    bit         pass_mode = 1'b0;

    wifi_to_ethernet_header_rewrite uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .push      (push),
        .push_item (push_item),
        .full      (full),
        .pop       (pop),
        .empty     (empty),
        .pop_item  (pop_item)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    // Bytes dropped ahead of the payload: MAC header, QoS field, LLC/SNAP.
    function automatic int hdr_total(input logic [1:0] ds, input bit qos);
        return ((ds == DS_WDS) ? HDR_WDS_LEN : HDR_BASE_LEN) + (qos ? QOS_LEN : 0) + LLC_LEN;
    endfunction

    task automatic report_mismatch(input string msg);
        fail_count++;
        if (fail_count <= MAX_PRINTS)
        begin
            $display("%0t ns: MISMATCH %s", $time, msg);
        end
    endtask

    task automatic expect_byte(input logic [7:0] b, input logic is_last, input logic st);
        out_item_t r;
        r.out_byte = b;
        r.out_last = is_last;
        r.status   = st;
        expected_results.push_back(r);
    endtask

    // Twelve address bytes chosen by the ToDS/FromDS bits, destination first.
    task automatic expect_prefix(input bit last_on_twelfth);
        logic [1:0] ds;
        int dst;
        int src;
        int i;
        ds  = hdr_store[1][1:0];
        dst = ds[0] ? ADDR3_OFS : ADDR1_OFS;
        case (ds)
            DS_NONE, DS_TO: src = ADDR2_OFS;
            DS_FROM:        src = ADDR3_OFS;
            default:        src = ADDR4_OFS;
        endcase
        for (i = 0; i < MAC_LEN; i++)
        begin
            expect_byte(hdr_store[dst + i], 1'b0, 1'b0);
        end
        for (i = 0; i < MAC_LEN; i++)
        begin
            expect_byte(hdr_store[src + i], last_on_twelfth && (i == MAC_LEN - 1), 1'b0);
        end
    endtask

    function automatic int stored_hdr_len();
        return hdr_total(hdr_store[1][1:0], hdr_store[0][7:4] == SUBTYPE_QOS);
    endfunction

    // Advances the predicted frame state by one accepted byte.
    task automatic rewrite_byte(input in_item_t it);
        int pos;
        int hlen;
        if (pass_mode || in_payload)
        begin
            expect_byte(it.in_byte, it.in_last, 1'b0);
            if (it.in_last)
            begin
                byte_pos   = '0;
                in_payload = 1'b0;
            end
            return;
        end
        pos = byte_pos;
        // First payload byte: the address prefix goes out ahead of it.
        if (pos >= 2 && pos >= stored_hdr_len())
        begin
            expect_prefix(1'b0);
            expect_byte(it.in_byte, it.in_last, 1'b0);
            if (it.in_last)
            begin
                byte_pos = '0;
            end
            else
            begin
                in_payload = 1'b1;
            end
            return;
        end
        if (pos < HDR_DEPTH)
        begin
            hdr_store[pos] = it.in_byte;
        end
        hlen = (pos < 1) ? HDR_DEPTH : stored_hdr_len();
        if (it.in_last)
        begin
            // A frame ending on its last header byte has an empty payload.
            if (pos + 1 == hlen)
            begin
                expect_prefix(1'b1);
            end
            else
            begin
                expect_byte(8'h00, 1'b1, 1'b1);
                short_frames++;
            end
            byte_pos = '0;
        end
        else
        begin
            byte_pos = 6'(pos + 1);
        end
    endtask

    task automatic queue_byte(input logic [7:0] b, input logic is_last);
        in_item_t it;
        it.in_byte = b;
        it.in_last = is_last;
        pending_bytes.push_back(it);
        items_queued++;
    endtask

    // Random frame bytes with the frame control fields forced as requested.
    task automatic build_frame(input logic [1:0] ds, input bit qos, input int len);
        int i;
        frame_buf.delete();
        for (i = 0; i < len; i++)
        begin
            frame_buf.push_back(8'($urandom));
        end
        if (qos)
        begin
            frame_buf[0][7:4] = SUBTYPE_QOS;
        end
        else if (frame_buf[0][7:4] == SUBTYPE_QOS)
        begin
            frame_buf[0][7:4] = 4'h0;
        end
        if (len > 1)
        begin
            frame_buf[1][1:0] = ds;
        end
    endtask

    task automatic send_span(input int lo, input int hi);
        int i;
        for (i = lo; i <= hi; i++)
        begin
            queue_byte(frame_buf[i], i == frame_buf.size() - 1);
        end
    endtask

    // Mostly well-formed frames, with some cut short inside the header.
    task automatic queue_random_frame();
        logic [1:0] ds;
        bit qos;
        int hlen;
        int kind;
        int len;
        ds   = 2'($urandom);
        qos  = $urandom_range(1);
        hlen = hdr_total(ds, qos);
        kind = $urandom_range(9);
        if (kind == 0)
        begin
            len = $urandom_range(hlen - 1, 1);
        end
        else if (kind == 1)
        begin
            len = hlen;
        end
        else
        begin
            len = hlen + $urandom_range(24, 1);
        end
        build_frame(ds, qos, len);
        send_span(0, len - 1);
    endtask

    // Waits until every queued byte is taken and every result has come back.
    task automatic wait_idle();
        do
        begin
            @(posedge clk);
            #1;
        end while (items_accepted != items_queued || expected_results.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_mode(input bit pass);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= pass;
        pass_mode = pass;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Sender: presents the next pending byte and holds it until it is taken.
    always @(negedge clk)
    begin
        if (rst_n && (!push || req_taken))
        begin
            req_taken = 1'b0;
            if (!tx_hold && pending_bytes.size() > 0 && (no_idle || $urandom_range(99) >= 20))
            begin
                push      <= 1'b1;
                push_item <= pending_bytes.pop_front();
            end
            else
            begin
                push <= 1'b0;
            end
        end
    end

    // Receiver: random pops, plus one long hold-off when armed.
    always @(negedge clk)
    begin
        if (long_stall_armed && !long_stall_done)
        begin
            rx_hold_left    = LONG_STALL;
            long_stall_done = 1'b1;
        end
        if (rx_hold_left > 0)
        begin
            rx_hold_left--;
            pop <= 1'b0;
        end
        else
        begin
            pop <= rst_n && (no_idle || $urandom_range(99) >= 20);
        end
    end

    // Monitor: predicts on each accepted byte and checks each accepted result.
    always @(posedge clk)
    begin : monitor
        out_item_t want;
        if (rst_n)
        begin
            if (push && !full)
            begin
                rewrite_byte(push_item);
                items_accepted++;
                req_taken = 1'b1;
            end
            if (pop && !empty)
            begin
                results_checked++;
                if (expected_results.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected result byte %02h last %0b status %0b",
                        pop_item.out_byte, pop_item.out_last, pop_item.status));
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (pop_item.out_byte !== want.out_byte)
                    begin
                        report_mismatch($sformatf("out_byte %02h, expected %02h",
                            pop_item.out_byte, want.out_byte));
                    end
                    if (pop_item.out_last !== want.out_last)
                    begin
                        report_mismatch($sformatf("out_last %0b, expected %0b",
                            pop_item.out_last, want.out_last));
                    end
                    if (pop_item.status !== want.status)
                    begin
                        report_mismatch($sformatf("status %0b, expected %0b",
                            pop_item.status, want.status));
                    end
                end
            end
            // Watchdog on cycles with no request moving on either side.
            if ((push && !full) || (pop && !empty))
            begin
                stall_cycles = 0;
            end
            else
            begin
                stall_cycles++;
                if (stall_cycles >= STALL_LIMIT)
                begin
                    $display("Timeout: no request accepted for %0d cycles", STALL_LIMIT);
                    $display("Simulation FAILED");
                    $finish;
                end
            end
        end
    end

    initial
    begin : stimulus
        int base;
        int i;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        set_mode(1'b0);

        // Directed: a one-byte frame, then a frame that ends on its last header byte.
        queue_byte(8'hFF, 1'b1);
        build_frame(DS_NONE, 1'b0, hdr_total(DS_NONE, 1'b0));
        for (i = 2; i < frame_buf.size(); i++)
        begin
            frame_buf[i] = i[0] ? 8'hFF : 8'h00;
        end
        send_span(0, frame_buf.size() - 1);
        wait_idle();

        // Directed pass-through bytes at both extremes.
        set_mode(1'b1);
        queue_byte(8'h00, 1'b0);
        queue_byte(8'hFF, 1'b1);
        wait_idle();

        // Mode change in the middle of a four-address QoS frame.
        set_mode(1'b0);
        build_frame(DS_WDS, 1'b1, hdr_total(DS_WDS, 1'b1) + 2);
        send_span(0, 9);
        wait_idle();
        set_mode(1'b1);
        for (i = 0; i < 5; i++)
        begin
            queue_byte(8'($urandom), 1'b0);
        end
        wait_idle();
        set_mode(1'b0);
        send_span(10, frame_buf.size() - 1);
        wait_idle();

        // Random conversion traffic, starting with a stretch without idles.
        base = items_queued;
        while (items_queued - base < 180)
        begin
            queue_random_frame();
        end
        no_idle = 1'b1;
        wait (items_accepted >= base + 80);
        no_idle = 1'b0;
        wait_idle();

        // Random pass-through traffic.
        set_mode(1'b1);
        for (i = 0; i < 60; i++)
        begin
            queue_byte(8'($urandom), $urandom_range(7) == 0);
        end
        wait_idle();

        // Conversion under back-pressure, then a sender pause until fully drained.
        set_mode(1'b0);
        base = items_queued;
        while (items_queued - base < 250)
        begin
            queue_random_frame();
        end
        long_stall_armed = 1'b1;
        wait (items_accepted >= base + 150);
        tx_hold = 1'b1;
        do
        begin
            @(posedge clk);
            #1;
        end while (expected_results.size() != 0 || push);
        tx_hold = 1'b0;
        wait_idle();

        $display("Sent %0d bytes in both modes, checked %0d results (%0d short frames).",
            items_accepted, results_checked, short_frames);
        $display("Covered all four address layouts, QoS frames, empty payloads and stalls.");
        if (fail_count == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ----- wifi_to_ethernet_header_rewrite.f -----
hdl/wteh_pkg.sv
hdl/wteh_front.sv
hdl/wteh_fifo.sv
hdl/wteh_back.sv
hdl/wifi_to_ethernet_header_rewrite.sv
tb/sv/testbench.sv
